// ===== rtl/core/stre_pkg.sv =====
// Package for the segment tree range extreme block: widths, codes, states and the merge function.
`timescale 1ns / 1ps

package stre_pkg;

  localparam int DATA_W     = 32;
  localparam int IDX_W      = 10;
  localparam int OP_W       = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int LEAVES_DEF = 1024;

  // Input tdata layout, lowest bit first
  localparam int IN_INDEX_LSB = 0;
  localparam int IN_VALUE_LSB = IN_INDEX_LSB + IDX_W;
  localparam int IN_LEFT_LSB  = IN_VALUE_LSB + DATA_W;
  localparam int IN_RIGHT_LSB = IN_LEFT_LSB + IDX_W;
  localparam int IN_BITS      = IN_RIGHT_LSB + IDX_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((DATA_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_MERGE_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDENTITY   = 1'b1;

  localparam logic signed [DATA_W-1:0] ID_RESET = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_Q_LEFT,
    ST_Q_RIGHT,
    ST_Q_OUT
  } state_t;

  // mode 0 keeps the larger, mode 1 the smaller (signed)
  function automatic logic signed [DATA_W-1:0] pick(
    input logic                     mode,
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    if (mode) begin
      return (b < a) ? b : a;
    end
    return (b > a) ? b : a;
  endfunction

endpackage

// ===== rtl/core/stre_node_mem.sv =====
// Tree node memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module stre_node_mem
  import stre_pkg::*;
#(
  parameter int ADDR_W = 11,
  parameter int WORD_W = DATA_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [WORD_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic signed [WORD_W-1:0] rd_data
);

  logic signed [WORD_W-1:0] mem [0:(1<<ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/segment_tree_range_extreme_top.sv =====
// Top level of the segment tree range extreme block: control sequencer, registers, output stage.
`timescale 1ns / 1ps

// Bottom-up segment tree over LEAVES signed 32-bit values held in one node
// memory of 2*P words (P = LEAVES rounded up to a power of two, node 1 is the
// root, leaf i is node P+i). Each input item carries an op in tuser: clear
// writes the identity value into every node, set writes one leaf and walks up
// recomputing each ancestor, query folds the nodes covering [left, right]
// into max or min (merge_mode) starting from the identity value and returns
// one result item. Only a query gives a result. Items are processed one at a
// time. A set does one memory read of the sibling and one write of the parent
// per level, a query uses two read slots per level (one for each range edge)
// plus a closing fold and the result load, and a clear sweeps the memory one
// word per cycle. After reset the same sweep (reset identity) runs before the
// first item is taken; configuration writes are accepted during it. A set with
// index at or beyond LEAVES and op code 3 are taken and do nothing. A query
// right edge beyond the last leaf saturates; an empty range returns the
// identity value. The result register lets the next item in while a result
// waits.

module segment_tree_range_extreme_top
  import stre_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_wen,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [DATA_W-1:0]      cfg_wdata,
  // input items
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // index, value, left_index, right_index, zero pad
  input  logic [OP_W-1:0]        s_tuser,   // op
  // result items
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // query_result
);

  localparam int LEVELS = $clog2(LEAVES);
  localparam int P      = 1 << LEVELS;
  localparam int NW     = LEVELS + 1;                 // node address width
  localparam int LW     = NW + 1;                     // range edges reach 2*P
  localparam int CW     = (IDX_W > LW) ? IDX_W : LW;  // leaf index compare width
  localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);
  localparam logic [CW-1:0] LAST_C   = CW'(LEAVES - 1);

  // registers
  state_t                   state, state_next;
  logic                     merge_mode;
  logic signed [DATA_W-1:0] identity;
  logic signed [DATA_W-1:0] fill, fill_next;
  logic [NW-1:0]            cnt, cnt_next;
  logic                     pend, pend_next;
  logic [NW-1:0]            node, node_next;
  logic signed [DATA_W-1:0] cur, cur_next;
  logic [LW-1:0]            l, l_next;
  logic [LW-1:0]            r, r_next;
  logic signed [DATA_W-1:0] acc, acc_next;

  // input fields
  logic [IDX_W-1:0]         in_index, in_left, in_right;
  logic signed [DATA_W-1:0] in_value;
  logic [CW-1:0]            idx_c, lo_c, hi_c, hi_sat;
  logic                     set_ok, range_ok;
  logic [NW-1:0]            leaf_node;

  // memory ports
  logic                     wr_en;
  logic [NW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic [NW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  logic signed [DATA_W-1:0] parent, absorbed;
  logic [LW-1:0]            r_dec;
  logic                     out_load;

  assign in_index = s_tdata[IN_INDEX_LSB +: IDX_W];
  assign in_value = s_tdata[IN_VALUE_LSB +: DATA_W];
  assign in_left  = s_tdata[IN_LEFT_LSB  +: IDX_W];
  assign in_right = s_tdata[IN_RIGHT_LSB +: IDX_W];

  assign idx_c     = CW'(in_index);
  assign lo_c      = CW'(in_left);
  assign hi_c      = CW'(in_right);
  assign hi_sat    = (hi_c > LAST_C) ? LAST_C : hi_c;
  assign set_ok    = idx_c < LEAVES_C;
  assign range_ok  = lo_c <= hi_sat;
  assign leaf_node = NW'(P) + NW'(in_index);

  assign parent   = pick(merge_mode, cur, rd_data);
  assign absorbed = pend ? pick(merge_mode, acc, rd_data) : acc;
  assign r_dec    = r - LW'(1);

  stre_node_mem #(
    .ADDR_W (NW),
    .WORD_W (DATA_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer
  always_comb begin
    state_next = state;
    fill_next  = fill;
    cnt_next   = cnt;
    pend_next  = pend;
    node_next  = node;
    cur_next   = cur;
    l_next     = l;
    r_next     = r;
    acc_next   = acc;
    wr_en      = 1'b0;
    wr_addr    = node;
    wr_data    = cur;
    rd_addr    = node ^ NW'(1);
    s_tready   = 1'b0;
    out_load   = 1'b0;

    case (state)
      ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = cnt;
        wr_data  = fill;
        cnt_next = cnt + NW'(1);
        if (cnt == {NW{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (s_tuser)
            OP_CLEAR: begin
              fill_next  = identity;
              cnt_next   = '0;
              state_next = ST_CLEAR;
            end
            OP_SET: begin
              if (set_ok) begin
                wr_en      = 1'b1;
                wr_addr    = leaf_node;
                wr_data    = in_value;
                node_next  = leaf_node;
                cur_next   = in_value;
                state_next = ST_SET_RD;
              end
            end
            OP_QUERY: begin
              // empty range: l = r = 0 ends the walk at once
              l_next     = range_ok ? LW'(P) + LW'(lo_c) : '0;
              r_next     = range_ok ? LW'(P) + LW'(hi_sat) + LW'(1) : '0;
              acc_next   = identity;
              pend_next  = 1'b0;
              state_next = ST_Q_LEFT;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SET_RD: begin
        // sibling read issued through the default read address
        if (node == NW'(1)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SET_WR;
        end
      end

      ST_SET_WR: begin
        wr_en      = 1'b1;
        wr_addr    = node >> 1;
        wr_data    = parent;
        cur_next   = parent;
        node_next  = node >> 1;
        state_next = ST_SET_RD;
      end

      ST_Q_LEFT: begin
        acc_next  = absorbed;
        pend_next = 1'b0;
        if (l < r) begin
          if (l[0]) begin
            rd_addr   = l[NW-1:0];
            pend_next = 1'b1;
            l_next    = l + LW'(1);
          end
          state_next = ST_Q_RIGHT;
        end else begin
          state_next = ST_Q_OUT;
        end
      end

      ST_Q_RIGHT: begin
        acc_next  = absorbed;
        pend_next = 1'b0;
        if (r[0]) begin
          rd_addr   = r_dec[NW-1:0];
          pend_next = 1'b1;
        end
        // r odd: (r-1)>>1 equals r>>1
        l_next     = l >> 1;
        r_next     = r >> 1;
        state_next = ST_Q_LEFT;
      end

      ST_Q_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      fill       <= ID_RESET;
      cnt        <= '0;
      pend       <= 1'b0;
      merge_mode <= 1'b0;
      identity   <= ID_RESET;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
      if (cfg_wen) begin
        case (cfg_addr)
          CFG_MERGE_MODE: merge_mode <= cfg_wdata[0];
          CFG_IDENTITY:   identity   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    node <= node_next;
    cur  <= cur_next;
    l    <= l_next;
    r    <= r_next;
    acc  <= acc_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_TDATA_W'(acc);
    end
  end

  // reset always starts the clearing sweep, so no item is taken right after it
  a_reset_sweep: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("item accepted during the reset sweep");

  // the upward walk never writes the root's parent slot
  a_set_node: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SET_WR) |-> (node > NW'(1)))
    else $error("set walk past the root");

  // left edge never passes the right edge inside a level
  a_query_edges: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_RIGHT) |-> (l <= r))
    else $error("query edges crossed");

  // a finished query waits while the previous result is still held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_OUT && m_tvalid && !m_tready) |=> (state == ST_Q_OUT))
    else $error("query result dropped");

endmodule

// ===== tb/segment_tree_range_extreme_top_test.sv =====
// Self-checking testbench for segment_tree_range_extreme_top: directed and random operations.
`timescale 1ns / 1ps

// Items enter through the s_* stream. tuser carries the op, and tdata packs index, value,
// left_index and right_index from bit 0 up. Only a query returns an item on m_*.
// A scoreboard class keeps its own copy of the node memory. Every accepted item is applied
// to that copy, and every query pushes its expected answer. Each returned item is checked
// against the oldest answer still waiting.
//
// The run has eight phases. Each phase writes both registers and then drives random items.
// Some phases change the merge or the identity without a clear. In those phases the inner
// nodes keep values merged under the old setting, and the model tracks them node by node.
// Between phases the testbench waits until every answer is back. It then waits one full
// clear sweep longer, because a clear or a set gives no result and may still be running.

module segment_tree_range_extreme_top_test;
  import stre_pkg::*;

  localparam int TREE_P        = 1 << $clog2(LEAVES_DEF);   // leaf i lives at node TREE_P+i
  localparam int SETTLE_CYCLES = 2 * TREE_P + 64;           // covers a clear still sweeping
  localparam int QUIET_LIMIT   = 20000;                     // cycles with no handshake or register write
  localparam int RANDOM_ITEMS  = 250;                       // per phase, eight phases
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;               // unused code, taken and dropped
  localparam logic [IDX_W-1:0] LAST_LEAF = IDX_W'(LEAVES_DEF - 1);
  localparam logic [IDX_W-1:0] NEXT_TO_LAST = IDX_W'(LEAVES_DEF - 2);

  // Shadow of the node memory plus the queue of query answers still owed by the block.
  class range_extreme_board;
    logic signed [DATA_W-1:0] nodes [2*TREE_P];
    logic                     min_mode;
    logic signed [DATA_W-1:0] ident;
    logic signed [DATA_W-1:0] pending_answers [$];
    int                       errors;

    function void power_up();
      min_mode = 1'b0;
      ident    = ID_RESET;
      foreach (nodes[i]) nodes[i] = ID_RESET;
      pending_answers.delete();
      errors = 0;
    endfunction

    function logic signed [DATA_W-1:0] keep(input logic signed [DATA_W-1:0] a,
                                            input logic signed [DATA_W-1:0] b);
      if (min_mode) return (b < a) ? b : a;
      return (b > a) ? b : a;
    endfunction

    function void take_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] val,
                            input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
      int unsigned              n, l, r, top;
      logic signed [DATA_W-1:0] acc;
      case (op)
        OP_CLEAR: begin
          foreach (nodes[i]) nodes[i] = ident;
        end
        OP_SET: begin
          if (idx < LEAVES_DEF) begin
            n = TREE_P + idx;
            nodes[n] = val;
            n = n >> 1;
            while (n != 0) begin
              nodes[n] = keep(nodes[2*n], nodes[2*n+1]);
              n = n >> 1;
            end
          end
        end
        OP_QUERY: begin
          top = (hi > LEAVES_DEF - 1) ? LEAVES_DEF - 1 : hi;
          acc = ident;
          if (lo <= top) begin
            l = TREE_P + lo;
            r = TREE_P + top + 1;
            while (l < r) begin
              if (l[0]) begin
                acc = keep(acc, nodes[l]);
                l++;
              end
              if (r[0]) begin
                r--;
                acc = keep(acc, nodes[r]);
              end
              l = l >> 1;
              r = r >> 1;
            end
          end
          pending_answers.push_back(acc);
        end
        default: ;
      endcase
    endfunction

    function void check_answer(input logic [OUT_TDATA_W-1:0] word);
      logic signed [DATA_W-1:0] got, want;
      got = word[DATA_W-1:0];
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: query_result with nothing waiting, expected none, actual %0d",
                 $time, got);
        return;
      end
      want = pending_answers.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: query_result expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_wen   = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [DATA_W-1:0]      cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [OP_W-1:0]        s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  range_extreme_board board;
  int  gap_mode    = 0;   // 0 back to back, 1 short gaps, 2 long gaps
  int  stall_mode  = 0;   // receiver pattern, see below
  int  burst_left  = 0;
  bit  valid_held  = 0;
  int  stall_left  = 0;
  int  stall_phase = 0;
  int  quiet_cycles = 0;

  segment_tree_range_extreme_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: checks whatever handshakes at this edge, then picks tready for the next one.
  // Modes: 0 always ready, 1 frequent random stalls, 2 occasional long stalls,
  // 3 a fixed repeating stall pattern.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_answer(m_tdata);
    stall_phase = (stall_phase + 1) % 8;
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19);
            m_tready <= 1'b0;
          end else begin
            m_tready <= 1'b1;
          end
        end
        default: m_tready <= (stall_phase >= 3);
      endcase
    end
  end

  // Watchdog: a long stretch without any handshake or register write means a hang.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Drives one item and holds it until it is taken. tvalid stays high into the next item
  // unless the burst ends with a gap; it is never dropped and raised in the same step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] val,
                           input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
    logic [IN_TDATA_W-1:0] word;
    int                    gap;
    word = '0;
    word[IN_INDEX_LSB +: IDX_W]  = idx;
    word[IN_VALUE_LSB +: DATA_W] = val;
    word[IN_LEFT_LSB  +: IDX_W]  = lo;
    word[IN_RIGHT_LSB +: IDX_W]  = hi;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= op;
    valid_held = 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.take_item(op, idx, val, lo, hi);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = (gap_mode == 0) ? 0 : $urandom_range(0, (gap_mode == 1) ? 3 : 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        valid_held = 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Writes both registers, merge first; the shadow follows each write as it lands.
  task automatic set_config(input logic mode, input logic signed [DATA_W-1:0] id);
    cfg_wen   <= 1'b1;
    cfg_addr  <= CFG_MERGE_MODE;
    cfg_wdata <= {{(DATA_W-1){1'b0}}, mode};
    @(posedge clk);
    board.min_mode = mode;
    cfg_addr  <= CFG_IDENTITY;
    cfg_wdata <= id;
    @(posedge clk);
    board.ident = id;
    cfg_wen <= 1'b0;
  endtask

  // Idle the sender, collect every owed answer, then let a trailing clear or set finish.
  task automatic quiesce();
    if (valid_held) begin
      s_tvalid <= 1'b0;
      valid_held = 0;
    end
    while (board.pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaf positions lean toward both ends of the tree.
  function automatic logic [IDX_W-1:0] rand_index();
    case ($urandom_range(0, 9))
      0, 1:    return IDX_W'($urandom_range(0, 7));
      2:       return IDX_W'($urandom_range(LEAVES_DEF - 8, LEAVES_DEF - 1));
      default: return IDX_W'($urandom_range(0, LEAVES_DEF - 1));
    endcase
  endfunction

  // Extremes and small values (plenty of ties) mixed with full-range data.
  function automatic logic signed [DATA_W-1:0] rand_value();
    int v;
    case ($urandom_range(0, 9))
      0:       v = 32'h7fff_ffff;
      1:       v = 32'h8000_0000;
      2, 3:    v = int'($urandom_range(0, 16)) - 8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic random_item();
    int                roll, span;
    logic [IDX_W-1:0]  lo, hi;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      send_item(OP_CLEAR, rand_index(), rand_value(), rand_index(), rand_index());
    end else if (roll < 5) begin
      send_item(OP_NONE, rand_index(), rand_value(), rand_index(), rand_index());
    end else if (roll < 52) begin
      send_item(OP_SET, rand_index(), rand_value(), rand_index(), rand_index());
    end else begin
      lo = rand_index();
      case ($urandom_range(0, 9))
        0: begin                     // empty range: left past right
          lo = IDX_W'($urandom_range(1, LEAVES_DEF - 1));
          hi = IDX_W'($urandom_range(0, lo - 1));
        end
        1: begin                     // whole tree
          lo = '0;
          hi = LAST_LEAF;
        end
        2, 3, 4, 5: begin            // short window
          span = lo + $urandom_range(0, 15);
          hi = (span > LEAVES_DEF - 1) ? LAST_LEAF : IDX_W'(span);
        end
        default: hi = IDX_W'($urandom_range(lo, LEAVES_DEF - 1));
      endcase
      send_item(OP_QUERY, rand_index(), rand_value(), lo, hi);
    end
  endtask

  initial begin
    logic                     mode_sel;
    logic signed [DATA_W-1:0] ident_sel;
    bit                       clear_first;
    board = new;
    board.power_up();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // after reset the block sweeps its memory; wait until it takes items
    repeat (2) @(posedge clk);
    while (!s_tready) @(posedge clk);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase > 0) quiesce();
      case (phase)
        0:       begin mode_sel = 1'b0; ident_sel = ID_RESET;      clear_first = 0; end
        1:       begin mode_sel = 1'b1; ident_sel = 32'h7fff_ffff; clear_first = 0; end
        2:       begin mode_sel = 1'b1; ident_sel = 32'h7fff_ffff; clear_first = 1; end
        3:       begin mode_sel = 1'b0; ident_sel = 0;             clear_first = 0; end
        4:       begin mode_sel = 1'b1; ident_sel = $urandom;      clear_first = 1; end
        5:       begin mode_sel = 1'b0; ident_sel = $urandom;      clear_first = 0; end
        6:       begin mode_sel = 1'b1; ident_sel = ID_RESET;      clear_first = 1; end
        default: begin mode_sel = 1'b0; ident_sel = 32'h7fff_ffff; clear_first = 1; end
      endcase
      set_config(mode_sel, ident_sel);
      gap_mode   = phase % 3;
      stall_mode = phase % 4;
      burst_left = 0;
      if (clear_first) send_item(OP_CLEAR, 0, 0, 0, 0);

      if (phase == 0) begin
        // untouched tree answers the reset identity
        send_item(OP_QUERY, 0, 0, 0, LAST_LEAF);
        // field extremes at both ends of the leaf row
        send_item(OP_SET, 0, 32'h7fff_ffff, 0, 0);
        send_item(OP_SET, LAST_LEAF, 32'h8000_0000, 0, 0);
        send_item(OP_SET, 512, -1, 0, 0);
        send_item(OP_SET, 511, 0, 0, 0);
        send_item(OP_QUERY, 0, 0, 0, LAST_LEAF);
        send_item(OP_QUERY, 0, 0, 0, 0);
        send_item(OP_QUERY, 0, 0, LAST_LEAF, LAST_LEAF);
        send_item(OP_QUERY, 0, 0, 1, NEXT_TO_LAST);
        send_item(OP_QUERY, 0, 0, 511, 512);
        // empty ranges give the identity
        send_item(OP_QUERY, 0, 0, 600, 100);
        send_item(OP_QUERY, 0, 0, LAST_LEAF, 0);
        // unused op code with every field bit set: no result, no change
        send_item(OP_NONE, '1, '1, '1, '1);
        send_item(OP_SET, LAST_LEAF, 5, 0, 0);
        send_item(OP_QUERY, 0, 0, 1000, LAST_LEAF);
        send_item(OP_SET, 341, 32'h5555_5555, 0, 0);
        send_item(OP_SET, 682, 32'haaaa_aaaa, 0, 0);
        send_item(OP_QUERY, 0, 0, 341, 682);
        send_item(OP_QUERY, 0, 0, 342, 681);
        // clear drops everything back to the identity
        send_item(OP_CLEAR, '1, '1, '1, '1);
        send_item(OP_QUERY, 0, 0, 0, LAST_LEAF);
        send_item(OP_QUERY, 0, 0, 5, 5);
        // leaf index above the row cannot be formed in 10 bits at 1024 leaves, and a right
        // edge never needs saturation; the top indexes above cover the boundary instead
      end

      repeat (RANDOM_ITEMS) random_item();
    end
    quiesce();

    if (board.errors == 0 && board.pending_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/stre_pkg.sv
rtl/core/stre_node_mem.sv
rtl/core/segment_tree_range_extreme_top.sv
tb/segment_tree_range_extreme_top_test.sv
